// File: hw/rtl/stjs_pkg.sv
package stjs_pkg;

  // Default table capacity.
  localparam int DEFAULT_MAX_ENTRIES = 1024;

  // Operation codes carried by in_op.
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Controller states.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FIRST = 2'd1;
  localparam logic [1:0] ST_JUMP  = 2'd2;
  localparam logic [1:0] ST_LIN   = 2'd3;

  // Next walk index selection.
  localparam logic [1:0] IDX_HOLD  = 2'd0;
  localparam logic [1:0] IDX_ZERO  = 2'd1;
  localparam logic [1:0] IDX_PROBE = 2'd2;
  localparam logic [1:0] IDX_INC   = 2'd3;

  // Table read address selection, relative to the next walk index.
  localparam logic [1:0] RD_NONE   = 2'd0;
  localparam logic [1:0] RD_BASE   = 2'd1;
  localparam logic [1:0] RD_BASE_K = 2'd2;
  localparam logic [1:0] RD_BASE_1 = 2'd3;

  typedef struct packed {
    logic       append;
    logic       clear;
    logic       load_target;
    logic [1:0] idx_sel;
    logic [1:0] rd_sel;
    logic       res_valid;
    logic       res_found;
  } stjs_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic eq;
    logic lt;
    logic gt;
    logic k_ok;
    logic one_ok;
  } stjs_status_t;

endpackage

// File: hw/rtl/stjs_ctrl.sv
module stjs_ctrl
  import stjs_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [1:0]   in_op,
  input  stjs_status_t status,
  output stjs_cmd_t    cmd,
  output logic         busy
);

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign busy = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (in_op)
            OP_APPEND: cmd.append = 1'b1;
            OP_CLEAR:  cmd.clear  = 1'b1;
            OP_QUERY: begin
              if (status.cnt_zero) begin
                cmd.res_valid = 1'b1;
              end else begin
                cmd.load_target = 1'b1;
                cmd.idx_sel     = IDX_ZERO;
                cmd.rd_sel      = RD_BASE;
                state_nxt       = ST_FIRST;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FIRST, ST_JUMP: begin
        if (state_r == ST_FIRST && status.eq) begin
          cmd.res_valid = 1'b1;
          cmd.res_found = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (state_r == ST_FIRST || status.lt) begin
          // Either the walk has just begun or the probe ahead was below the
          // target and becomes the new position: try another jump.
          cmd.idx_sel = (state_r == ST_JUMP) ? IDX_PROBE : IDX_HOLD;
          if (status.k_ok) begin
            cmd.rd_sel = RD_BASE_K;
            state_nxt  = ST_JUMP;
          end else if (status.one_ok) begin
            cmd.rd_sel = RD_BASE_1;
            state_nxt  = ST_LIN;
          end else begin
            cmd.res_valid = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else begin
          // Jumping stops here; scan forward from the current position.
          if (status.one_ok) begin
            cmd.rd_sel = RD_BASE_1;
            state_nxt  = ST_LIN;
          end else begin
            cmd.res_valid = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end
      end
      ST_LIN: begin
        if (status.eq) begin
          cmd.res_valid = 1'b1;
          cmd.res_found = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (status.gt) begin
          cmd.res_valid = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          cmd.idx_sel = IDX_INC;
          if (status.one_ok) begin
            cmd.rd_sel = RD_BASE_1;
          end else begin
            cmd.res_valid = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/stjs_dp.sv
module stjs_dp
  import stjs_pkg::*;
#(
  parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic signed [31:0]  in_item_value,
  input  stjs_cmd_t           cmd,
  output stjs_status_t        status,
  output logic                out_valid,
  output logic                out_found
);

  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W  = $clog2(MAX_ENTRIES);
  localparam int STEP_W = CNT_W / 2 + 1;
  localparam int SUM_W  = CNT_W + 1;

  logic signed [31:0] table_mem [MAX_ENTRIES];
  logic signed [31:0] rdata_r;
  logic signed [31:0] target_r;

  logic [CNT_W-1:0]  count_r;
  logic [STEP_W-1:0] step_r;
  logic [SUM_W-1:0]  nsq_r;
  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  probe_r;
  logic              out_valid_r;
  logic              out_found_r;

  logic [IDX_W-1:0]  base;
  logic [SUM_W-1:0]  sum_k;
  logic [SUM_W-1:0]  sum_1;
  logic [SUM_W-1:0]  count_inc;
  logic [IDX_W-1:0]  rd_addr;
  logic              full;

  assign full      = (count_r == CNT_W'(MAX_ENTRIES));
  assign count_inc = SUM_W'(count_r) + SUM_W'(1);

  always_comb begin
    case (cmd.idx_sel)
      IDX_ZERO:  base = '0;
      IDX_PROBE: base = probe_r;
      IDX_INC:   base = idx_r + IDX_W'(1);
      default:   base = idx_r;
    endcase
  end

  assign sum_k = SUM_W'(base) + SUM_W'(step_r);
  assign sum_1 = SUM_W'(base) + SUM_W'(1);

  always_comb begin
    case (cmd.rd_sel)
      RD_BASE_K: rd_addr = sum_k[IDX_W-1:0];
      RD_BASE_1: rd_addr = sum_1[IDX_W-1:0];
      default:   rd_addr = base;
    endcase
  end

  assign status.cnt_zero = (count_r == '0);
  assign status.eq       = (rdata_r == target_r);
  assign status.lt       = (rdata_r < target_r);
  assign status.gt       = (rdata_r > target_r);
  assign status.k_ok     = (sum_k < SUM_W'(count_r));
  assign status.one_ok   = (sum_1 < SUM_W'(count_r));

  // Table storage: one write port for appends, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.append && !full) begin
      table_mem[count_r[IDX_W-1:0]] <= in_item_value;
    end
    if (cmd.rd_sel != RD_NONE) begin
      rdata_r <= table_mem[rd_addr];
    end
  end

  // Payload registers of the walk.
  always_ff @(posedge clk) begin
    if (cmd.load_target) begin
      target_r <= in_item_value;
    end
    idx_r <= base;
    if (cmd.rd_sel == RD_BASE_K) begin
      probe_r <= sum_k[IDX_W-1:0];
    end
    out_found_r <= cmd.res_found;
  end

  // The step follows floor(sqrt(count)); nsq_r holds the square of step + 1.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      step_r      <= STEP_W'(1);
      nsq_r       <= SUM_W'(4);
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.res_valid;
      if (cmd.clear) begin
        count_r <= '0;
        step_r  <= STEP_W'(1);
        nsq_r   <= SUM_W'(4);
      end else if (cmd.append && !full) begin
        count_r <= count_inc[CNT_W-1:0];
        if (count_inc == nsq_r) begin
          step_r <= step_r + STEP_W'(1);
          nsq_r  <= nsq_r + (SUM_W'(step_r) << 1) + SUM_W'(3);
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_found = out_found_r;

endmodule

// File: hw/rtl/sorted_table_jump_search.sv
// Sorted table with jump search membership queries.
// A command word is taken on in_op and in_item_value at a rising edge where
// start is high and busy is low. An append word stores the value at the end of
// the table (dropped once the table holds MAX_ENTRIES values), a clear word
// empties the table, and both complete with no result and with busy staying
// low. Operation code 3 is ignored.
// A query word raises busy and walks the table with a step equal to the
// integer square root of the entry count: one table read per cycle, first
// jumping by the step and then scanning one entry at a time. The result word
// appears on out_found with out_valid high for exactly one cycle, in the cycle
// after the walk ends; busy is low in that same cycle. A query on an empty
// table answers in the next cycle. Otherwise the walk takes one read for the
// first entry, one per probe ahead (each jump and the probe that ends
// jumping) and one per scan step, all through the single read port of the
// table memory.
// The receiver cannot stall, so every result word must be taken as it comes.
// Reset empties the table, returns the step to 1, drops any walk in progress
// and issues no result; table contents need no clearing.
module sorted_table_jump_search
  import stjs_pkg::*;
#(
  parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_op,
  input  logic signed [31:0] in_item_value,
  output logic               out_valid,
  output logic               out_found
);

  stjs_cmd_t    cmd;
  stjs_status_t status;

  // The controller sequences the walk; it sees only compare and bound flags.
  stjs_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_op  (in_op),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // The datapath holds the table memory, the count, the step and the walk
  // registers, and registers the result word.
  stjs_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_item_value (in_item_value),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_found     (out_found)
  );

`ifndef SYNTH
  // A result word only follows a walk or a query command.
  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) || $past(start)))
    else $error("result word without a preceding query");

  // A result word leaves the block ready for the next command.
  a_idle_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("busy still high while a result word is shown");

  // A walk never ends without delivering its result word.
  a_walk_ends_in_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> out_valid)
    else $error("query walk ended without a result word");
`endif

endmodule
